// ===== rtl/hgp_pkg.sv =====
// ----------------------------------------------------------------------------
// hgp_pkg
// Shared types and constants for the hex board point pick block.
// ----------------------------------------------------------------------------
package hgp_pkg;

    // fixed field widths
    localparam int BOARD_W      = 5;
    localparam int GEOM_W       = 8;
    localparam int CELL_INDEX_W = 8;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BOARD_CELLS     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEX_RADIUS      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEX_HALF_TOP    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEX_HALF_HEIGHT = 8'd3;

    // register values after reset
    localparam logic [BOARD_W-1:0] RST_BOARD_CELLS     = 5'd11;
    localparam logic [GEOM_W-1:0]  RST_HEX_RADIUS      = 8'd30;
    localparam logic [GEOM_W-1:0]  RST_HEX_HALF_TOP    = 8'd15;
    localparam logic [GEOM_W-1:0]  RST_HEX_HALF_HEIGHT = 8'd26;

    // hexagon edges, counterclockwise from the right vertex
    typedef enum logic [2:0] {
        EDGE_RIGHT_UP,
        EDGE_TOP,
        EDGE_LEFT_UP,
        EDGE_LEFT_DOWN,
        EDGE_BOTTOM,
        EDGE_RIGHT_DOWN
    } edge_t;

    // edge test request to the cross product unit
    typedef struct packed {
        logic  valid;
        edge_t edge_sel;
    } edge_cmd_t;

    // edge test answer, in the cycle after the request
    typedef struct packed {
        logic valid;
        logic outside;
    } edge_rsp_t;

    // scan sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    // sequencer status toward the stream side
    typedef struct packed {
        logic idle;
        logic res_valid;
        logic res_found;
    } seq_status_t;

endpackage

// ===== rtl/hgp_cross.sv =====
// ----------------------------------------------------------------------------
// hgp_cross
// Shared edge test unit: one signed cross product a x b per request, sign
// reported in the cycle after the request.
// ----------------------------------------------------------------------------
module hgp_cross #(
    parameter int XW = 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hgp_pkg::edge_cmd_t           cmd,
    input  logic signed [XW-1:0]         dx,
    input  logic signed [XW-1:0]         dy,
    input  logic [hgp_pkg::GEOM_W-1:0]   hex_radius,
    input  logic [hgp_pkg::GEOM_W-1:0]   hex_half_top,
    input  logic [hgp_pkg::GEOM_W-1:0]   hex_half_height,
    output hgp_pkg::edge_rsp_t           rsp
);

    localparam int CW = hgp_pkg::GEOM_W + 2;
    localparam int TW = XW + 1;
    localparam int PW = CW + TW;
    localparam int SW = PW + 1;

    logic signed [CW-1:0] rr;
    logic signed [CW-1:0] ww;
    logic signed [CW-1:0] hh;
    logic signed [CW-1:0] w_minus_r;
    logic signed [CW-1:0] r_minus_w;
    logic signed [CW-1:0] w_twice;
    logic signed [TW-1:0] rt;
    logic signed [TW-1:0] wt;
    logic signed [TW-1:0] ht;
    logic signed [TW-1:0] dx_t;
    logic signed [TW-1:0] dy_t;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [PW-1:0] prod1;
    logic signed [PW-1:0] prod2;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic                 v_reg;
    logic signed [SW-1:0] cross_sum;

    // shape coefficients and offsets
    assign rr        = signed'(CW'(hex_radius));
    assign ww        = signed'(CW'(hex_half_top));
    assign hh        = signed'(CW'(hex_half_height));
    assign w_minus_r = ww - rr;
    assign r_minus_w = rr - ww;
    assign w_twice   = ww + ww;
    assign rt        = signed'(TW'(hex_radius));
    assign wt        = signed'(TW'(hex_half_top));
    assign ht        = signed'(TW'(hex_half_height));
    assign dx_t      = TW'(dx);
    assign dy_t      = TW'(dy);

    // operand select: cross = c1 * t1 + c2 * t2 for the chosen edge
    always_comb
    begin
        c1 = '0;
        c2 = '0;
        t1 = '0;
        t2 = '0;
        case (cmd.edge_sel)
            hgp_pkg::EDGE_RIGHT_UP:
            begin
                c1 = w_minus_r;
                t1 = dy_t;
                c2 = -hh;
                t2 = dx_t - rt;
            end
            hgp_pkg::EDGE_TOP:
            begin
                c1 = -w_twice;
                t1 = dy_t - ht;
            end
            hgp_pkg::EDGE_LEFT_UP:
            begin
                c1 = w_minus_r;
                t1 = dy_t - ht;
                c2 = hh;
                t2 = dx_t + wt;
            end
            hgp_pkg::EDGE_LEFT_DOWN:
            begin
                c1 = r_minus_w;
                t1 = dy_t;
                c2 = hh;
                t2 = dx_t + rt;
            end
            hgp_pkg::EDGE_BOTTOM:
            begin
                c1 = w_twice;
                t1 = dy_t + ht;
            end
            hgp_pkg::EDGE_RIGHT_DOWN:
            begin
                c1 = r_minus_w;
                t1 = dy_t + ht;
                c2 = -hh;
                t2 = dx_t - wt;
            end
            default:
            begin
                c1 = '0;
            end
        endcase
    end

    // the two multipliers
    assign prod1 = c1 * t1;
    assign prod2 = c2 * t2;

    // product registers
    always_ff @(posedge clk)
    begin
        p1_reg <= prod1;
        p2_reg <= prod2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= cmd.valid;
        end
    end

    // sum and sign test
    assign cross_sum   = SW'(p1_reg) + SW'(p2_reg);
    assign rsp.valid   = v_reg;
    assign rsp.outside = cross_sum[SW-1];

endmodule

// ===== rtl/hgp_seq.sv =====
// ----------------------------------------------------------------------------
// hgp_seq
// Scan sequencer: walks the board cells in column order, tracks the cell
// centre and index, and runs an edge test for every edge of each cell.
// ----------------------------------------------------------------------------
module hgp_seq #(
    parameter int MAX_BOARD  = 16,
    parameter int COORD_BITS = 16,
    parameter int XW         = 18
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [COORD_BITS-1:0]     point_x,
    input  logic signed [COORD_BITS-1:0]     point_y,
    input  logic [hgp_pkg::BOARD_W-1:0]      board_cells,
    input  logic [hgp_pkg::GEOM_W-1:0]       hex_radius,
    input  logic [hgp_pkg::GEOM_W-1:0]       hex_half_top,
    input  logic [hgp_pkg::GEOM_W-1:0]       hex_half_height,
    output hgp_pkg::edge_cmd_t               cmd,
    input  hgp_pkg::edge_rsp_t               rsp,
    output logic signed [XW-1:0]             dx,
    output logic signed [XW-1:0]             dy,
    input  logic                             res_taken,
    output hgp_pkg::seq_status_t             status,
    output logic [hgp_pkg::CELL_INDEX_W-1:0] res_index,
    output logic [COORD_BITS-1:0]            res_cx,
    output logic [COORD_BITS-1:0]            res_cy
);

    localparam int NMAX = (MAX_BOARD < 31) ? MAX_BOARD : 31;
    localparam int IW   = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int NW   = $clog2(NMAX + 1);

    hgp_pkg::seq_state_t state_reg, state_next;
    hgp_pkg::edge_t      edge_reg, edge_next;

    logic signed [COORD_BITS-1:0]      px_reg, px_next;
    logic signed [COORD_BITS-1:0]      py_reg, py_next;
    logic [NW-1:0]                     n_reg, n_next;
    logic [IW-1:0]                     i_reg, i_next;
    logic [IW-1:0]                     j_reg, j_next;
    logic [hgp_pkg::CELL_INDEX_W-1:0]  idx_reg, idx_next;
    logic signed [XW-1:0]              cx_reg, cx_next;
    logic signed [XW-1:0]              cy_reg, cy_next;
    logic signed [XW-1:0]              bx_reg, bx_next;
    logic signed [XW-1:0]              by_reg, by_next;
    logic signed [XW-1:0]              dx_reg, dx_next;
    logic signed [XW-1:0]              dy_reg, dy_next;
    logic                              outside_reg, outside_next;
    logic                              found_reg, found_next;

    logic [NW-1:0]                     n_eff;
    logic [hgp_pkg::GEOM_W:0]          step_sum;
    logic signed [XW-1:0]              step_x;
    logic signed [XW-1:0]              step_y;
    logic                              last_i;
    logic                              last_j;
    logic                              miss;

    // board size clamp and centre steps
    assign n_eff    = (32'(board_cells) > NMAX) ? NW'(NMAX) : NW'(board_cells);
    assign step_sum = {1'b0, hex_radius} + {1'b0, hex_half_top};
    assign step_x   = signed'(XW'(step_sum));
    assign step_y   = signed'(XW'(hex_half_height));
    assign last_i   = (NW'(i_reg) == (n_reg - NW'(1)));
    assign last_j   = (NW'(j_reg) == (n_reg - NW'(1)));
    assign miss     = outside_reg | (rsp.valid & rsp.outside);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hgp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        edge_reg    <= edge_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        idx_reg     <= idx_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        outside_reg <= outside_next;
        found_reg   <= found_next;
    end

    // next state and scan control
    always_comb
    begin
        state_next   = state_reg;
        edge_next    = edge_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        idx_next     = idx_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        outside_next = outside_reg;
        found_next   = found_reg;
        case (state_reg)
            hgp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    px_next    = point_x;
                    py_next    = point_y;
                    n_next     = n_eff;
                    i_next     = '0;
                    j_next     = '0;
                    idx_next   = '0;
                    cx_next    = '0;
                    cy_next    = '0;
                    bx_next    = '0;
                    by_next    = '0;
                    found_next = 1'b0;
                    state_next = (n_eff == '0) ? hgp_pkg::ST_DONE : hgp_pkg::ST_LOAD;
                end
            end
            hgp_pkg::ST_LOAD:
            begin
                // point relative to the current centre
                dx_next      = XW'(px_reg) - cx_reg;
                dy_next      = XW'(py_reg) - cy_reg;
                edge_next    = hgp_pkg::EDGE_RIGHT_UP;
                outside_next = 1'b0;
                state_next   = hgp_pkg::ST_ISSUE;
            end
            hgp_pkg::ST_ISSUE:
            begin
                outside_next = miss;
                if (edge_reg == hgp_pkg::EDGE_RIGHT_DOWN)
                begin
                    state_next = hgp_pkg::ST_DRAIN;
                end
                else
                begin
                    edge_next = hgp_pkg::edge_t'(3'(edge_reg) + 3'd1);
                end
            end
            hgp_pkg::ST_DRAIN:
            begin
                if (!miss)
                begin
                    found_next = 1'b1;
                    state_next = hgp_pkg::ST_DONE;
                end
                else if (last_i && last_j)
                begin
                    state_next = hgp_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 8'd1;
                    state_next = hgp_pkg::ST_LOAD;
                    if (last_i)
                    begin
                        // next column starts one step right and one step down
                        i_next  = '0;
                        j_next  = j_reg + IW'(1);
                        bx_next = bx_reg + step_x;
                        by_next = by_reg - step_y;
                        cx_next = bx_reg + step_x;
                        cy_next = by_reg - step_y;
                    end
                    else
                    begin
                        i_next  = i_reg + IW'(1);
                        cx_next = cx_reg + step_x;
                        cy_next = cy_reg + step_y;
                    end
                end
            end
            hgp_pkg::ST_DONE:
            begin
                if (res_taken)
                begin
                    state_next = hgp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hgp_pkg::ST_IDLE;
            end
        endcase
    end

    // edge requests and result fields
    assign cmd.valid        = (state_reg == hgp_pkg::ST_ISSUE);
    assign cmd.edge_sel     = edge_reg;
    assign dx               = dx_reg;
    assign dy               = dy_reg;
    assign status.idle      = (state_reg == hgp_pkg::ST_IDLE);
    assign status.res_valid = (state_reg == hgp_pkg::ST_DONE);
    assign status.res_found = found_reg;
    assign res_index        = found_reg ? idx_reg : '0;
    assign res_cx           = found_reg ? cx_reg[COORD_BITS-1:0] : '0;
    assign res_cy           = found_reg ? cy_reg[COORD_BITS-1:0] : '0;

    // every issued edge answers in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hgp_pkg::ST_ISSUE |=> rsp.valid)
        else $error("edge answer missing after request");

    // scan counters stay inside the board while scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hgp_pkg::ST_LOAD || state_reg == hgp_pkg::ST_ISSUE ||
         state_reg == hgp_pkg::ST_DRAIN)
        |-> (NW'(i_reg) < n_reg && NW'(j_reg) < n_reg))
        else $error("scan counter beyond board size");

    // a start leaves idle at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hgp_pkg::ST_IDLE && start) |=> state_reg != hgp_pkg::ST_IDLE)
        else $error("start not taken");

    // a result holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hgp_pkg::ST_DONE && !res_taken) |=>
        (state_reg == hgp_pkg::ST_DONE && $stable(found_reg)))
        else $error("result dropped before transfer");

endmodule

// ===== rtl/hex_grid_point_hit_test.sv =====
// ----------------------------------------------------------------------------
// hex_grid_point_hit_test
// Finds the first cell of a rhombic hexagon board that holds a query point.
// ----------------------------------------------------------------------------
// scan: cells are tested up to and including the hit (all cells on a miss);
//   each cell takes a load, an edge issue for every hexagon edge, then a drain of the shared unit
// the next input is taken once the scan has handed its result to the output
//   register, so only one point is in the scan at a time
// reset: registers return to 11 / 30 / 15 / 26, output register empty
module hex_grid_point_hit_test #(
    parameter int MAX_BOARD  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hgp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hgp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: cell_index, centre_x, centre_y
    output logic [((8+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tuser: found
    output logic [0:0]                      m_axis_tuser
);

    localparam int CW    = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int XW    = CW + 2;
    localparam int OUT_W = ((8 + 2 * COORD_BITS + 7) / 8) * 8;

    logic [hgp_pkg::BOARD_W-1:0] board_cells_reg;
    logic [hgp_pkg::GEOM_W-1:0]  hex_radius_reg;
    logic [hgp_pkg::GEOM_W-1:0]  hex_half_top_reg;
    logic [hgp_pkg::GEOM_W-1:0]  hex_half_height_reg;

    hgp_pkg::edge_cmd_t          cmd;
    hgp_pkg::edge_rsp_t          rsp;
    hgp_pkg::seq_status_t        status;
    logic signed [XW-1:0]        dx;
    logic signed [XW-1:0]        dy;
    logic [hgp_pkg::CELL_INDEX_W-1:0] res_index;
    logic [COORD_BITS-1:0]       res_cx;
    logic [COORD_BITS-1:0]       res_cy;
    logic                        start;
    logic                        res_taken;

    logic                        m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]            m_data_reg;
    logic                        m_found_reg;

    // config register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_cells_reg     <= hgp_pkg::RST_BOARD_CELLS;
            hex_radius_reg      <= hgp_pkg::RST_HEX_RADIUS;
            hex_half_top_reg    <= hgp_pkg::RST_HEX_HALF_TOP;
            hex_half_height_reg <= hgp_pkg::RST_HEX_HALF_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hgp_pkg::REG_BOARD_CELLS:
                    board_cells_reg <= cfg_data[hgp_pkg::BOARD_W-1:0];
                hgp_pkg::REG_HEX_RADIUS:
                    hex_radius_reg <= cfg_data;
                hgp_pkg::REG_HEX_HALF_TOP:
                    hex_half_top_reg <= cfg_data;
                hgp_pkg::REG_HEX_HALF_HEIGHT:
                    hex_half_height_reg <= cfg_data;
                default:
                begin
                    board_cells_reg <= board_cells_reg;
                end
            endcase
        end
    end

    // input transfer starts a scan
    assign s_axis_tready = status.idle;
    assign start         = s_axis_tvalid && s_axis_tready;

    hgp_seq #(
        .MAX_BOARD  (MAX_BOARD),
        .COORD_BITS (COORD_BITS),
        .XW         (XW)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .point_x         (s_axis_tdata[COORD_BITS-1:0]),
        .point_y         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .board_cells     (board_cells_reg),
        .hex_radius      (hex_radius_reg),
        .hex_half_top    (hex_half_top_reg),
        .hex_half_height (hex_half_height_reg),
        .cmd             (cmd),
        .rsp             (rsp),
        .dx              (dx),
        .dy              (dy),
        .res_taken       (res_taken),
        .status          (status),
        .res_index       (res_index),
        .res_cx          (res_cx),
        .res_cy          (res_cy)
    );

    hgp_cross #(
        .XW (XW)
    ) u_cross (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dx              (dx),
        .dy              (dy),
        .hex_radius      (hex_radius_reg),
        .hex_half_top    (hex_half_top_reg),
        .hex_half_height (hex_half_height_reg),
        .rsp             (rsp)
    );

    // output register, refilled as soon as the previous result leaves
    assign res_taken = status.res_valid && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_taken)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            m_data_reg  <= OUT_W'({res_cy, res_cx, res_index});
            m_found_reg <= status.res_found;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_found_reg;

    // no new input while a scan is running
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready)
        else $error("input taken during scan");

    // a result only enters a free or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        res_taken |=> m_axis_tvalid)
        else $error("result lost at output register");

endmodule

// ===== tb/hex_grid_point_hit_test_tb.sv =====
// ----------------------------------------------------------------------------
// hex_grid_point_hit_test_tb
// Self-checking bench for the hex board point pick. A directed table covers
// board extremes, shared vertices, register decode and odd shapes. Random
// phases then sweep board sizes and hexagon shapes, aiming most points at
// cells, vertices and edges. Every result is scored against a local cell
// scan model, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module hex_grid_point_hit_test_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BOARD  = 16;
    localparam int COORD_BITS = 16;
    localparam int S_W        = ((2*COORD_BITS+7)/8)*8;
    localparam int M_W        = ((8+2*COORD_BITS+7)/8)*8;
    localparam int NUM_DIR    = 32;
    localparam int HOLD_LEN   = 400;

    // register indexes with no register behind them
    localparam logic [hgp_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LOW  = 8'd4;
    localparam logic [hgp_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = 8'hFF;

    typedef struct packed {
        logic                   found;
        logic [7:0]             cell_index;
        logic signed [15:0]     centre_x;
        logic signed [15:0]     centre_y;
    } pick_t;

    localparam pick_t NO_HIT = '0;

    typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [7:0]             reg_index;
        logic [7:0]             reg_data;
        logic signed [15:0]     px;
        logic signed [15:0]     py;
        logic                   typed;
        pick_t                  want;
    } dir_row_t;

    typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_SLOW} rx_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [hgp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [hgp_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_W-1:0]         s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_W-1:0]         m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    // local copy of the configuration
    logic [hgp_pkg::BOARD_W-1:0] cur_cells;
    logic [hgp_pkg::GEOM_W-1:0]  cur_radius;
    logic [hgp_pkg::GEOM_W-1:0]  cur_half_top;
    logic [hgp_pkg::GEOM_W-1:0]  cur_half_height;

    pick_t                  pending_picks[$];
    pick_t                  seen_pick;
    pick_t                  due_pick;
    dir_row_t               dir_rows [NUM_DIR];
    int                     mismatch_count = 0;
    int                     burst_left = 0;
    bit                     hold_req = 1'b0;
    int                     hold_left = 0;
    int                     mode_left = 0;
    rx_mode_t               rx_mode = RX_STEADY;

    hex_grid_point_hit_test #(
        .MAX_BOARD  (MAX_BOARD),
        .COORD_BITS (COORD_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // tdata: point_x, point_y
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // tdata: cell_index, centre_x, centre_y
        .m_axis_tdata  (m_axis_tdata),
        // tuser: found
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    // point against every edge of a hexagon centred at the origin
    function automatic bit in_hexagon(input longint qx, input longint qy);
        longint vx[6];
        longint vy[6];
        longint ax, ay, bx, by;
        int     k, nk;
        vx[0] = cur_radius;         vy[0] = 0;
        vx[1] = cur_half_top;       vy[1] = cur_half_height;
        vx[2] = -vx[1];             vy[2] = vy[1];
        vx[3] = -vx[0];             vy[3] = 0;
        vx[4] = -vx[1];             vy[4] = -vy[1];
        vx[5] = vx[1];              vy[5] = -vy[1];
        for (k = 0; k < 6; k++)
        begin
            nk = (k == 5) ? 0 : k + 1;
            ax = vx[nk] - vx[k];
            ay = vy[nk] - vy[k];
            bx = qx - vx[k];
            by = qy - vy[k];
            // strictly right of an edge means outside
            if (ax * by - ay * bx < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // first cell in column-major scan order that holds the point
    function automatic pick_t predict_pick(input logic signed [15:0] px,
                                           input logic signed [15:0] py);
        pick_t  res;
        longint n, stride, rise, cx, cy;
        int     i, j;
        res    = NO_HIT;
        n      = (cur_cells > MAX_BOARD) ? MAX_BOARD : cur_cells;
        stride = longint'(cur_radius) + longint'(cur_half_top);
        rise   = longint'(cur_half_height);
        for (j = 0; j < n; j++)
        begin
            for (i = 0; i < n; i++)
            begin
                cx = (i + j) * stride;
                cy = (i - j) * rise;
                if (in_hexagon(longint'(px) - cx, longint'(py) - cy))
                begin
                    res.found      = 1'b1;
                    res.cell_index = 8'(n * j + i);
                    res.centre_x   = 16'(cx);
                    res.centre_y   = 16'(cy);
                    return res;
                end
            end
        end
        return res;
    endfunction

    // random point: mostly near cells, on vertices or on flat edges
    function automatic void aim_point(output logic [15:0] px, output logic [15:0] py);
        int n_eff, pick, i, j, k, dx, dy, rr, ww, hh, cx, cy;
        n_eff = (cur_cells > MAX_BOARD) ? MAX_BOARD : cur_cells;
        rr    = cur_radius;
        ww    = cur_half_top;
        hh    = cur_half_height;
        pick  = $urandom_range(0, 99);
        i     = 0;
        j     = 0;
        if (n_eff > 0)
        begin
            i = $urandom_range(0, n_eff - 1);
            j = $urandom_range(0, n_eff - 1);
        end
        cx = (i + j) * (rr + ww);
        cy = (i - j) * hh;
        dx = 0;
        dy = 0;
        if (pick < 40)
        begin
            // corner, possibly nudged by one unit
            k = $urandom_range(0, 5);
            case (k)
                0: begin dx = rr;  dy = 0;   end
                1: begin dx = ww;  dy = hh;  end
                2: begin dx = -ww; dy = hh;  end
                3: begin dx = -rr; dy = 0;   end
                4: begin dx = -ww; dy = -hh; end
                default: begin dx = ww; dy = -hh; end
            endcase
            dx = dx + int'($urandom_range(0, 2)) - 1;
            dy = dy + int'($urandom_range(0, 2)) - 1;
        end
        else if (pick < 55)
        begin
            // exactly on the top or bottom edge
            dx = int'($urandom_range(0, 2 * ww)) - ww;
            dy = $urandom_range(0, 1) ? hh : -hh;
        end
        else
        begin
            dx = int'($urandom_range(0, 2 * rr + 6)) - (rr + 3);
            dy = int'($urandom_range(0, 2 * hh + 6)) - (hh + 3);
        end
        px = 16'(cx + dx);
        py = 16'(cy + dy);
        // any coordinate at all
        if (pick >= 75)
        begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
    endfunction

    function automatic dir_row_t hit_row(input int x, input int y, input int idx,
                                         input int cx, input int cy);
        dir_row_t row;
        row                 = '0;
        row.kind            = ROW_POINT;
        row.px              = 16'(x);
        row.py              = 16'(y);
        row.typed           = 1'b1;
        row.want.found      = 1'b1;
        row.want.cell_index = 8'(idx);
        row.want.centre_x   = 16'(cx);
        row.want.centre_y   = 16'(cy);
        return row;
    endfunction

    function automatic dir_row_t miss_row(input int x, input int y);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_POINT;
        row.px    = 16'(x);
        row.py    = 16'(y);
        row.typed = 1'b1;
        return row;
    endfunction

    function automatic dir_row_t point_row(input int x, input int y);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_POINT;
        row.px   = 16'(x);
        row.py   = 16'(y);
        return row;
    endfunction

    function automatic dir_row_t write_row(input logic [7:0] idx, input logic [7:0] data);
        dir_row_t row;
        row           = '0;
        row.kind      = ROW_WRITE;
        row.reg_index = idx;
        row.reg_data  = data;
        return row;
    endfunction

    // wait until every expected result has come back
    task automatic wait_drained();
        while (pending_picks.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one register write transfer, entered and left at a falling edge
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            hgp_pkg::REG_BOARD_CELLS:     cur_cells       = data[hgp_pkg::BOARD_W-1:0];
            hgp_pkg::REG_HEX_RADIUS:      cur_radius      = data;
            hgp_pkg::REG_HEX_HALF_TOP:    cur_half_top    = data;
            hgp_pkg::REG_HEX_HALF_HEIGHT: cur_half_height = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one point transfer; valid stays up only when another point follows at once
    task automatic push_point(input logic [15:0] x, input logic [15:0] y,
                              input pick_t want, input bit more);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 15)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_picks.push_back(want);
        burst_left--;
        @(negedge clk);
        if (!more || burst_left == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    // output side stall pattern, with one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(30, 300);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STEADY: m_axis_tready <= 1'b1;
                    RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
                    default:   m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // score each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_pick.found      = m_axis_tuser[0];
            seen_pick.cell_index = m_axis_tdata[7:0];
            seen_pick.centre_x   = m_axis_tdata[23:8];
            seen_pick.centre_y   = m_axis_tdata[39:24];
            if (pending_picks.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with nothing expected: found=%0b index=%0d ",
                         $time, seen_pick.found, seen_pick.cell_index,
                         "centre=(%0d,%0d)", seen_pick.centre_x, seen_pick.centre_y);
            end
            else
            begin
                due_pick = pending_picks.pop_front();
                if (seen_pick !== due_pick)
                begin
                    mismatch_count++;
                    $display("%0t: expected found=%0b index=%0d centre=(%0d,%0d), ",
                             $time, due_pick.found, due_pick.cell_index,
                             due_pick.centre_x, due_pick.centre_y,
                             "got found=%0b index=%0d centre=(%0d,%0d)",
                             seen_pick.found, seen_pick.cell_index,
                             seen_pick.centre_x, seen_pick.centre_y);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int          row, ph, k, cnt;
        logic [7:0]  nb, rr, ww, hh;
        logic [15:0] qx, qy;
        pick_t       want;
        bit          more;

        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cur_cells       = hgp_pkg::RST_BOARD_CELLS;
        cur_radius      = hgp_pkg::RST_HEX_RADIUS;
        cur_half_top    = hgp_pkg::RST_HEX_HALF_TOP;
        cur_half_height = hgp_pkg::RST_HEX_HALF_HEIGHT;

        // reset board: 11 per side, centres 45 apart in x and 26 in y
        dir_rows[0]  = hit_row(0, 0, 0, 0, 0);
        dir_rows[1]  = hit_row(30, 0, 0, 0, 0);
        dir_rows[2]  = miss_row(-31, 0);
        dir_rows[3]  = miss_row(32767, 32767);
        dir_rows[4]  = miss_row(-32768, -32768);
        dir_rows[5]  = miss_row(32767, -32768);
        dir_rows[6]  = miss_row(-32768, 32767);
        dir_rows[7]  = hit_row(45, 26, 1, 45, 26);
        dir_rows[8]  = hit_row(45, -26, 11, 45, -26);
        dir_rows[9]  = hit_row(900, 0, 120, 900, 0);
        dir_rows[10] = hit_row(450, 260, 10, 450, 260);
        dir_rows[11] = hit_row(450, -260, 110, 450, -260);
        // vertex shared by neighbors, and just past the far corner
        dir_rows[12] = point_row(15, 26);
        dir_rows[13] = point_row(931, 0);
        // writes to unmapped indexes leave the board alone
        dir_rows[14] = write_row(REG_UNMAPPED_LOW, 8'd1);
        dir_rows[15] = hit_row(45, -26, 11, 45, -26);
        dir_rows[16] = write_row(REG_UNMAPPED_HIGH, 8'd0);
        dir_rows[17] = hit_row(0, 20, 0, 0, 0);
        // empty board
        dir_rows[18] = write_row(hgp_pkg::REG_BOARD_CELLS, 8'd0);
        dir_rows[19] = miss_row(0, 0);
        // oversized board is clamped to the maximum
        dir_rows[20] = write_row(hgp_pkg::REG_BOARD_CELLS, 8'hFF);
        dir_rows[21] = hit_row(1350, 0, 255, 1350, 0);
        // widest cells, negative centre y
        dir_rows[22] = write_row(hgp_pkg::REG_HEX_RADIUS, 8'd255);
        dir_rows[23] = write_row(hgp_pkg::REG_HEX_HALF_TOP, 8'd255);
        dir_rows[24] = write_row(hgp_pkg::REG_HEX_HALF_HEIGHT, 8'd255);
        dir_rows[25] = hit_row(7650, -3825, 240, 7650, -3825);
        // flat and non-convex shapes
        dir_rows[26] = write_row(hgp_pkg::REG_HEX_HALF_HEIGHT, 8'd0);
        dir_rows[27] = point_row(0, 0);
        dir_rows[28] = write_row(hgp_pkg::REG_HEX_RADIUS, 8'd10);
        dir_rows[29] = write_row(hgp_pkg::REG_HEX_HALF_HEIGHT, 8'd40);
        dir_rows[30] = point_row(0, 0);
        dir_rows[31] = point_row(100, 40);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (row = 0; row < NUM_DIR; row++)
        begin
            if (dir_rows[row].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(dir_rows[row].reg_index, dir_rows[row].reg_data);
            end
            else
            begin
                want = dir_rows[row].typed ? dir_rows[row].want
                                           : predict_pick(dir_rows[row].px, dir_rows[row].py);
                more = (row + 1 < NUM_DIR) && (dir_rows[row + 1].kind == ROW_POINT);
                push_point(dir_rows[row].px, dir_rows[row].py, want, more);
            end
        end

        // random phases, one board setting each
        for (ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: begin nb = 8'd1; rr = 8'd255; ww = 8'd255; hh = 8'd255; cnt = 120; end
                1: begin nb = 8'd2; rr = 8'd1; ww = 8'd0; hh = 8'd1; cnt = 120; end
                2: begin nb = 8'hFF; rr = 8'd30; ww = 8'd15; hh = 8'd26; cnt = 25; end
                3:
                begin
                    nb  = {3'($urandom_range(0, 7)), 5'd0};
                    rr  = 8'($urandom_range(1, 255));
                    ww  = 8'($urandom_range(0, 255));
                    hh  = 8'($urandom_range(1, 255));
                    cnt = 40;
                end
                4: begin nb = 8'd3; rr = 8'd10; ww = 8'd40; hh = 8'd20; cnt = 150; end
                5:
                begin
                    nb  = 8'd4;
                    rr  = 8'($urandom_range(1, 255));
                    ww  = 8'($urandom_range(0, 255));
                    hh  = 8'd0;
                    cnt = 120;
                end
                6:
                begin
                    nb  = 8'd16;
                    rr  = 8'($urandom_range(1, 40));
                    ww  = 8'($urandom_range(0, 40));
                    hh  = 8'($urandom_range(1, 40));
                    cnt = 20;
                end
                default:
                begin
                    nb  = {3'($urandom_range(0, 7)), 5'($urandom_range(1, 5))};
                    rr  = 8'($urandom_range(1, 255));
                    ww  = 8'($urandom_range(0, 255));
                    hh  = 8'($urandom_range(0, 255));
                    cnt = 170;
                end
            endcase
            wait_drained();
            write_reg(hgp_pkg::REG_BOARD_CELLS, nb);
            write_reg(hgp_pkg::REG_HEX_RADIUS, rr);
            write_reg(hgp_pkg::REG_HEX_HALF_TOP, ww);
            write_reg(hgp_pkg::REG_HEX_HALF_HEIGHT, hh);
            if (ph == 3)
            begin
                write_reg(REG_UNMAPPED_LOW, 8'($urandom));
                write_reg(REG_UNMAPPED_HIGH, 8'($urandom));
            end
            for (k = 0; k < cnt; k++)
            begin
                aim_point(qx, qy);
                want = predict_pick(qx, qy);
                more = (k != cnt - 1) && !(ph == 4 && k == 74);
                push_point(qx, qy, want, more);
                // long output hold while points keep coming
                if (ph == 1 && k == 40)
                    hold_req = 1'b1;
                // sender pause until the block is empty
                if (ph == 4 && k == 74)
                    wait_drained();
            end
        end

        // drain and watch for stray results
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
